FILE: rtl/t2ss_pkg.sv
package t2ss_pkg;

  localparam int TEMP_W = 16;
  localparam int SEG_W  = 8;
  localparam int WHOLE_W = TEMP_W - 4;

  localparam logic [SEG_W-1:0] SEG_MINUS      = 8'hBF;
  localparam logic [SEG_W-1:0] SEG_BLANK      = 8'hFF;
  localparam logic [SEG_W-1:0] SEG_POINT_MASK = 8'h7F;

  typedef logic [SEG_W-1:0] seg_t;

  function automatic seg_t glyph(input logic [3:0] digit);
    seg_t g;
    case (digit)
      4'h0:    g = 8'hC0;
      4'h1:    g = 8'hF9;
      4'h2:    g = 8'hA4;
      4'h3:    g = 8'hB0;
      4'h4:    g = 8'h99;
      4'h5:    g = 8'h92;
      4'h6:    g = 8'h82;
      4'h7:    g = 8'hF8;
      4'h8:    g = 8'h80;
      4'h9:    g = 8'h90;
      4'hA:    g = 8'h88;
      4'hB:    g = 8'h83;
      4'hC:    g = 8'hC6;
      4'hD:    g = 8'hA1;
      4'hE:    g = 8'h86;
      default: g = 8'h8E;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/temp_to_seven_segment_top.sv
// an input transfer passes the registered stages below to the out_ ports
// throughput: one temperature per cycle while out_stall is low
// a stalled output holds the whole pipeline in place
// reset: synchronous, active low; clears the stage valid bits only
module temp_to_seven_segment_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [t2ss_pkg::TEMP_W-1:0] in_temperature,
  output logic                          out_valid,
  input  logic                          out_stall,
  output t2ss_pkg::seg_t                out_seg_fraction,
  output t2ss_pkg::seg_t                out_seg_ones,
  output t2ss_pkg::seg_t                out_seg_tens,
  output t2ss_pkg::seg_t                out_seg_hundreds,
  output t2ss_pkg::seg_t                out_seg_thousands,
  output t2ss_pkg::seg_t                out_seg_top
);
  import t2ss_pkg::*;

  logic advance;

  // valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1: magnitude
  logic [TEMP_W-1:0]  mag_nxt;
  logic [7:0]         tenths_prod;
  logic [WHOLE_W-1:0] s1_whole_r;
  logic [3:0]         s1_tenths_r;
  logic               s1_neg_r;

  // stage 2: whole / 10
  logic [23:0]        q1_prod;
  logic [8:0]         s2_q1_r;
  logic [WHOLE_W-1:0] s2_whole_r;
  logic [3:0]         s2_tenths_r;
  logic               s2_neg_r;

  // stage 3: ones digit, whole / 100
  logic [WHOLE_W-1:0] rem0_nxt;
  logic [16:0]        q2_prod;
  logic [3:0]         s3_d0_r;
  logic [8:0]         s3_q1_r;
  logic [5:0]         s3_q2_r;
  logic               s3_q1nz_r;
  logic [3:0]         s3_tenths_r;
  logic               s3_neg_r;

  // stage 4: tens digit, whole / 1000
  logic [8:0]         rem1_nxt;
  logic [9:0]         q3_prod;
  logic [3:0]         s4_d0_r;
  logic [3:0]         s4_d1_r;
  logic [5:0]         s4_q2_r;
  logic [2:0]         s4_q3_r;
  logic               s4_q1nz_r;
  logic               s4_q2nz_r;
  logic [3:0]         s4_tenths_r;
  logic               s4_neg_r;

  // stage 5: segment codes
  logic [5:0]         rem2_nxt;
  logic               q3nz;
  seg_t               frac_nxt, ones_nxt, tens_nxt, hund_nxt, thou_nxt, top_nxt;
  seg_t               frac_r, ones_r, tens_r, hund_r, thou_r, top_r;

  assign advance  = !(v5_r && out_stall);
  assign in_stall = !advance;

  always_comb begin
    mag_nxt     = in_temperature[TEMP_W-1] ? (~in_temperature + 16'd1) : in_temperature;
    tenths_prod = {4'd0, mag_nxt[3:0]} * 8'd10;
    q1_prod     = {12'd0, s1_whole_r} * 24'd3277;
    rem0_nxt    = s2_whole_r - {s2_q1_r, 3'd0} - {2'd0, s2_q1_r, 1'b0};
    q2_prod     = {8'd0, s2_q1_r} * 17'd205;
    rem1_nxt    = s3_q1_r - {s3_q2_r, 3'd0} - {2'd0, s3_q2_r, 1'b0};
    q3_prod     = {4'd0, s3_q2_r} * 10'd13;
    rem2_nxt    = s4_q2_r - {s4_q3_r, 3'd0} - {2'd0, s4_q3_r, 1'b0};
    q3nz        = (s4_q3_r != 3'd0);

    frac_nxt = glyph(s4_tenths_r);
    ones_nxt = glyph(s4_d0_r) & SEG_POINT_MASK;
    tens_nxt = s4_q1nz_r ? glyph(s4_d1_r) : (s4_neg_r ? SEG_MINUS : SEG_BLANK);
    hund_nxt = s4_q2nz_r ? glyph(rem2_nxt[3:0])
                         : ((s4_neg_r && s4_q1nz_r) ? SEG_MINUS : SEG_BLANK);
    thou_nxt = q3nz ? glyph({1'b0, s4_q3_r})
                    : ((s4_neg_r && s4_q2nz_r) ? SEG_MINUS : SEG_BLANK);
    top_nxt  = (s4_neg_r && q3nz) ? SEG_MINUS : SEG_BLANK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_whole_r  <= mag_nxt[TEMP_W-1:4];
      s1_tenths_r <= tenths_prod[7:4];
      s1_neg_r    <= in_temperature[TEMP_W-1];

      s2_q1_r     <= q1_prod[23:15];
      s2_whole_r  <= s1_whole_r;
      s2_tenths_r <= s1_tenths_r;
      s2_neg_r    <= s1_neg_r;

      s3_d0_r     <= rem0_nxt[3:0];
      s3_q1_r     <= s2_q1_r;
      s3_q2_r     <= q2_prod[16:11];
      s3_q1nz_r   <= (s2_q1_r != 9'd0);
      s3_tenths_r <= s2_tenths_r;
      s3_neg_r    <= s2_neg_r;

      s4_d0_r     <= s3_d0_r;
      s4_d1_r     <= rem1_nxt[3:0];
      s4_q2_r     <= s3_q2_r;
      s4_q3_r     <= q3_prod[9:7];
      s4_q1nz_r   <= s3_q1nz_r;
      s4_q2nz_r   <= (s3_q2_r != 6'd0);
      s4_tenths_r <= s3_tenths_r;
      s4_neg_r    <= s3_neg_r;

      frac_r <= frac_nxt;
      ones_r <= ones_nxt;
      tens_r <= tens_nxt;
      hund_r <= hund_nxt;
      thou_r <= thou_nxt;
      top_r  <= top_nxt;
    end
  end

  assign out_valid         = v5_r;
  assign out_seg_fraction  = frac_r;
  assign out_seg_ones      = ones_r;
  assign out_seg_tens      = tens_r;
  assign out_seg_hundreds  = hund_r;
  assign out_seg_thousands = thou_r;
  assign out_seg_top       = top_r;

  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted transfer did not enter the first stage");

  a_point_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_seg_ones[7] && out_seg_fraction[7]))
    else $error("decimal point misplaced");

  a_sign_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_seg_top == SEG_MINUS) |->
      (out_seg_thousands != SEG_BLANK && out_seg_thousands != SEG_MINUS))
    else $error("minus sign not adjacent to leading digit");

endmodule
